### rtl/tq_pkg.sv
// ----------------------------------------------------------------------------
// tq_pkg: shared types and constants of the timed event queue
// Holds the slot record layout, operation and status codes, state and walk mode codes
// and the wrap-aware deadline compare.
// ----------------------------------------------------------------------------
`default_nettype none

package tq_pkg;

   // operation codes (req_tuser)
   localparam logic [1:0] FUNC_REGISTER = 2'd0;
   localparam logic [1:0] FUNC_CANCEL   = 2'd1;
   localparam logic [1:0] FUNC_RUN      = 2'd2;

   // result status codes (rsp_tuser)
   localparam logic [1:0] STAT_DONE       = 2'd0;
   localparam logic [1:0] STAT_FULL       = 2'd1;
   localparam logic [1:0] STAT_NOT_ACTIVE = 2'd2;
   localparam logic [1:0] STAT_NOTHING    = 2'd3;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_WRD    = 3'd2;
   localparam logic [2:0] ST_WCHK   = 3'd3;
   localparam logic [2:0] ST_LINKA  = 3'd4;
   localparam logic [2:0] ST_LINKB  = 3'd5;
   localparam logic [2:0] ST_QSTART = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   // list walk purposes
   localparam logic [1:0] MODE_INS = 2'd0;
   localparam logic [1:0] MODE_DEL = 2'd1;
   localparam logic [1:0] MODE_RUN = 2'd2;
   localparam logic [1:0] MODE_QRY = 2'd3;

   localparam logic [15:0] NO_EVENT_WAIT_RESET = 16'd500;

   // one slot record; flags bit0 repeat, bit1 skip in query
   typedef struct packed {
      logic [31:0] deadline;
      logic [30:0] period;
      logic [7:0]  tag;
      logic [1:0]  flags;
   } slot_rec_type;

   // a is at or before b under a wrapping 32-bit clock
   function automatic logic at_or_before(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d == 32'd0) || d[31];
   endfunction

endpackage

`default_nettype wire

### rtl/timed_event_queue.sv
// ----------------------------------------------------------------------------
// timed_event_queue: deadline-ordered queue of timed events
// Linked list of slots kept in two RAMs (slot records and links), walked
// one entry at a time by a small sequencer.
//
//   channel   direction  handshake             contents
//   req_      in         req_tvalid/tready     tuser: func; tdata: event fields
//   rsp_      out        rsp_tvalid/tready     tuser: status; tdata: result
//   csr_      in         csr_valid/ready       no_event_wait (16 bit)
//
// Each list entry visited takes a RAM read (ST_WRD), then a compare
// (ST_WCHK). An item does at most one update walk and one next-wait walk
// over QUEUE_SLOTS entries. Reset is synchronous; slot RAMs need no clearing,
// the used bits and the list head are cleared at once. A stalled rsp_ holds
// the sequencer in its output state; one new item may be taken while a
// result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_queue
   import tq_pkg::*;
#(
   parameter int QUEUE_SLOTS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [31:0] now, [62:32] delay, [63] repeat_req, [71:64] tag,
   // [72] skip_in_query, [76:73] handle, [79:77] zero
   input  wire [79:0]  req_tdata,
   // [1:0] func
   input  wire [1:0]   req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [3:0] new_handle, [4] fired, [12:5] fired_tag, [44:13] next_wait,
   // [47:45] zero
   output logic [47:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [15:0]  csr_data
);

   localparam int IW = $clog2(QUEUE_SLOTS);
   localparam int SW = $clog2(QUEUE_SLOTS + 1);
   localparam logic [SW-1:0] NIL = SW'(QUEUE_SLOTS);
   localparam int RW = $bits(slot_rec_type);

   // control state
   logic [2:0]             state_ff, state_in;
   logic [1:0]             mode_ff, mode_in;
   logic [SW-1:0]          head_ff, head_in;
   logic [QUEUE_SLOTS-1:0] used_ff, used_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            new_wait_ff;

   // item and walk registers
   logic [1:0]    func_ff;
   logic [31:0]   now_ff;
   logic [30:0]   delay_ff;
   logic          rep_ff, skip_ff;
   logic [7:0]    tag_ff;
   logic [3:0]    handle_ff;
   logic [SW-1:0] cur_ff, cur_in, prev_ff, prev_in, steps_ff, steps_in;
   logic [IW-1:0] ins_slot_ff, ins_slot_in;
   logic [31:0]   ins_dl_ff, ins_dl_in;
   logic [1:0]    status_ff, status_in;
   logic [3:0]    new_handle_ff, new_handle_in;
   logic          fired_ff, fired_in;
   logic [7:0]    fired_tag_ff, fired_tag_in;
   logic [31:0]   wait_ff, wait_in;

   // response register
   logic [1:0]  rsp_status_ff;
   logic [3:0]  rsp_handle_ff;
   logic        rsp_fired_ff;
   logic [7:0]  rsp_tag_ff;
   logic [31:0] rsp_wait_ff;

   // RAM ports
   logic          dwr_en, lwr_en, rd_en;
   logic [IW-1:0] dwr_addr, lwr_addr;
   slot_rec_type  dwr_data, rd_rec;
   logic [SW-1:0] lwr_data, rd_link;
   logic [RW-1:0] rd_rec_bits;

   logic          req_acc, load_rsp;
   logic [IW-1:0] free_idx;
   logic          free_any, handle_ok;
   logic [31:0]   rearm_dl;

   tq_ram #(.WIDTH(RW), .DEPTH(QUEUE_SLOTS)) u_rec_ram (
      .clock   (clock),
      .wr_en   (dwr_en),
      .wr_addr (dwr_addr),
      .wr_data (dwr_data),
      .rd_en   (rd_en),
      .rd_addr (cur_ff[IW-1:0]),
      .rd_data (rd_rec_bits)
   );

   tq_ram #(.WIDTH(SW), .DEPTH(QUEUE_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (lwr_en),
      .wr_addr (lwr_addr),
      .wr_data (lwr_data),
      .rd_en   (rd_en),
      .rd_addr (cur_ff[IW-1:0]),
      .rd_data (rd_link)
   );

   assign rd_rec = slot_rec_type'(rd_rec_bits);

   // find the lowest free slot
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IW'(i);
            free_any = 1'b1;
         end
      end
   end

   assign handle_ok = ({28'd0, handle_ff} < 32'(QUEUE_SLOTS)) && used_ff[IW'(handle_ff)];
   assign rearm_dl  = now_ff + {1'b0, rd_rec.period};

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign load_rsp   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      head_in       = head_ff;
      used_in       = used_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      ins_slot_in   = ins_slot_ff;
      ins_dl_in     = ins_dl_ff;
      status_in     = status_ff;
      new_handle_in = new_handle_ff;
      fired_in      = fired_ff;
      fired_tag_in  = fired_tag_ff;
      wait_in       = wait_ff;
      rsp_valid_in  = rsp_valid_ff;
      dwr_en        = 1'b0;
      dwr_addr      = cur_ff[IW-1:0];
      dwr_data      = rd_rec;
      lwr_en        = 1'b0;
      lwr_addr      = prev_ff[IW-1:0];
      lwr_data      = rd_link;
      rd_en         = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               status_in     = STAT_DONE;
               new_handle_in = 4'd0;
               fired_in      = 1'b0;
               fired_tag_in  = 8'd0;
               state_in      = ST_START;
            end
         end
         ST_START: begin
            cur_in   = head_ff;
            prev_in  = NIL;
            steps_in = '0;
            state_in = ST_QSTART;
            case (func_ff)
               FUNC_REGISTER: begin
                  if (!free_any) begin
                     status_in = STAT_FULL;
                  end else begin
                     dwr_en            = 1'b1;
                     dwr_addr          = free_idx;
                     dwr_data.deadline = now_ff + {1'b0, delay_ff};
                     dwr_data.period   = delay_ff;
                     dwr_data.tag      = tag_ff;
                     dwr_data.flags    = {skip_ff, rep_ff};
                     used_in[free_idx] = 1'b1;
                     ins_slot_in       = free_idx;
                     ins_dl_in         = now_ff + {1'b0, delay_ff};
                     new_handle_in     = 4'(free_idx);
                     mode_in           = MODE_INS;
                     state_in          = ST_WRD;
                  end
               end
               FUNC_CANCEL: begin
                  if (!handle_ok) begin
                     status_in = STAT_NOT_ACTIVE;
                  end else begin
                     mode_in  = MODE_DEL;
                     state_in = ST_WRD;
                  end
               end
               FUNC_RUN: begin
                  if (head_ff == NIL) begin
                     status_in = STAT_NOTHING;
                  end else begin
                     mode_in  = MODE_RUN;
                     state_in = ST_WRD;
                  end
               end
               default: begin
                  state_in = ST_QSTART;
               end
            endcase
         end
         ST_WRD: begin
            if (cur_ff == NIL || steps_ff == NIL) begin
               // end of list reached
               case (mode_ff)
                  MODE_INS: state_in = ST_LINKA;
                  MODE_QRY: begin
                     wait_in  = {16'd0, new_wait_ff};
                     state_in = ST_OUT;
                  end
                  default:  state_in = ST_QSTART;
               endcase
            end else begin
               rd_en    = 1'b1;
               state_in = ST_WCHK;
            end
         end
         ST_WCHK: begin
            // advance by default
            prev_in  = cur_ff;
            cur_in   = rd_link;
            steps_in = steps_ff + 1'b1;
            state_in = ST_WRD;
            case (mode_ff)
               MODE_INS: begin
                  if (at_or_before(ins_dl_ff, rd_rec.deadline)) begin
                     prev_in  = prev_ff;
                     cur_in   = cur_ff;
                     steps_in = steps_ff;
                     state_in = ST_LINKA;
                  end
               end
               MODE_DEL: begin
                  if (cur_ff == SW'(handle_ff)) begin
                     if (prev_ff == NIL) begin
                        head_in = rd_link;
                     end else begin
                        lwr_en = 1'b1;
                     end
                     used_in[cur_ff[IW-1:0]] = 1'b0;
                     state_in = ST_QSTART;
                  end
               end
               MODE_RUN: begin
                  if (!at_or_before(rd_rec.deadline, now_ff)) begin
                     status_in = STAT_NOTHING;
                     state_in  = ST_QSTART;
                  end else begin
                     fired_in     = 1'b1;
                     fired_tag_in = rd_rec.tag;
                     head_in      = rd_link;
                     if (rd_rec.flags[0]) begin
                        // re-arm in the same slot and insert again
                        dwr_en            = 1'b1;
                        dwr_data.deadline = rearm_dl;
                        ins_slot_in       = cur_ff[IW-1:0];
                        ins_dl_in         = rearm_dl;
                        prev_in           = NIL;
                        steps_in          = '0;
                        mode_in           = MODE_INS;
                     end else begin
                        used_in[cur_ff[IW-1:0]] = 1'b0;
                        state_in = ST_QSTART;
                     end
                  end
               end
               default: begin
                  if (!rd_rec.flags[1]) begin
                     wait_in  = rd_rec.deadline - now_ff;
                     state_in = ST_OUT;
                  end
               end
            endcase
         end
         ST_LINKA: begin
            lwr_en   = 1'b1;
            lwr_addr = ins_slot_ff;
            lwr_data = cur_ff;
            if (prev_ff == NIL) begin
               head_in  = SW'(ins_slot_ff);
               state_in = ST_QSTART;
            end else begin
               state_in = ST_LINKB;
            end
         end
         ST_LINKB: begin
            lwr_en   = 1'b1;
            lwr_data = SW'(ins_slot_ff);
            state_in = ST_QSTART;
         end
         ST_QSTART: begin
            cur_in   = head_ff;
            prev_in  = NIL;
            steps_in = '0;
            mode_in  = MODE_QRY;
            state_in = ST_WRD;
         end
         ST_OUT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NIL;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         new_wait_ff  <= NO_EVENT_WAIT_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            new_wait_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      ins_slot_ff   <= ins_slot_in;
      ins_dl_ff     <= ins_dl_in;
      status_ff     <= status_in;
      new_handle_ff <= new_handle_in;
      fired_ff      <= fired_in;
      fired_tag_ff  <= fired_tag_in;
      wait_ff       <= wait_in;
      if (req_acc) begin
         func_ff   <= req_tuser;
         now_ff    <= req_tdata[31:0];
         delay_ff  <= req_tdata[62:32];
         rep_ff    <= req_tdata[63];
         tag_ff    <= req_tdata[71:64];
         skip_ff   <= req_tdata[72];
         handle_ff <= req_tdata[76:73];
      end
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_handle_ff <= new_handle_ff;
         rsp_fired_ff  <= fired_ff;
         rsp_tag_ff    <= fired_tag_ff;
         rsp_wait_ff   <= wait_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'd0, rsp_wait_ff, rsp_tag_ff, rsp_fired_ff, rsp_handle_ff};

   // the list head always names a slot in use
   a_head_used: assert property (@(posedge clock) disable iff (reset)
      (head_ff != NIL) |-> used_ff[head_ff[IW-1:0]])
      else $error("list head names a free slot");

   // a walk never runs past the slot count
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WCHK) |-> (steps_ff < NIL))
      else $error("list walk exceeded slot count");

   // a slot being linked in is marked used
   a_link_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINKA) |-> used_ff[ins_slot_ff])
      else $error("linking a free slot");

   // only a successful item may report a fired event
   a_fired_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_DONE)) |-> !rsp_fired_ff)
      else $error("fired reported with failing status");

endmodule

`default_nettype wire

### rtl/tq_ram.sv
// ----------------------------------------------------------------------------
// tq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire                       rd_en,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write, then read registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the timed event queue
// Drives register, cancel, run and unused operations through the request
// stream, predicts each response with a local model of the deadline list and
// compares it field by field. Random idling on both sides, a long response
// hold-off that fills the block, and a drain pause are part of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
   import tq_pkg::*;
();

   localparam int NSLOT = 16;
   localparam int NIL = NSLOT;
   localparam int WATCH_LIMIT = 20000;

   // selector with no operation behind it
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  func;
      logic [31:0] now;
      logic [30:0] delay;
      logic        rep;
      logic [7:0]  tag;
      logic        skip;
      logic [3:0]  handle;
   } event_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  new_handle;
      logic        fired;
      logic [7:0]  fired_tag;
      logic [31:0] next_wait;
   } event_rsp_type;

   // model of the slot list and the expected responses
   class event_queue_scoreboard;
      logic [31:0]   deadline[NSLOT];
      logic [30:0]   period[NSLOT];
      logic [7:0]    tag[NSLOT];
      logic [1:0]    flags[NSLOT];
      bit            used[NSLOT];
      int            link[NSLOT];
      int            head;
      logic [15:0]   idle_wait;
      event_rsp_type pending[$];
      int            errors;

      function new();
         foreach (used[i]) begin
            used[i] = 0;
            link[i] = NIL;
         end
         head = NIL;
         idle_wait = NO_EVENT_WAIT_RESET;
         errors = 0;
      endfunction

      function bit due_by(logic [31:0] a, logic [31:0] b);
         logic [31:0] d;
         d = a - b;
         return d == 0 || d[31];
      endfunction

      function void insert_slot(int s);
         int prev, cur, n;
         prev = NIL;
         cur = head;
         n = 0;
         while (cur < NIL && n < NSLOT) begin
            if (due_by(deadline[s], deadline[cur])) break;
            prev = cur;
            cur = link[cur];
            n++;
         end
         link[s] = cur;
         if (prev < NIL) link[prev] = s;
         else head = s;
      endfunction

      function void remove_slot(int s);
         int prev, cur, n;
         prev = NIL;
         cur = head;
         n = 0;
         while (cur < NIL && n < NSLOT) begin
            if (cur == s) begin
               if (prev < NIL) link[prev] = link[cur];
               else head = link[cur];
               return;
            end
            prev = cur;
            cur = link[cur];
            n++;
         end
      endfunction

      function int free_slots();
         int c;
         c = 0;
         foreach (used[i]) if (!used[i]) c++;
         return c;
      endfunction

      // note an accepted request and queue its response
      function void note_request(event_req_type r);
         event_rsp_type e;
         int s, cur, n;
         e = '{STAT_DONE, 4'd0, 1'b0, 8'd0, 32'd0};
         case (r.func)
            FUNC_REGISTER: begin
               s = NIL;
               for (int i = 0; i < NSLOT; i++)
                  if (!used[i]) begin
                     s = i;
                     break;
                  end
               if (s == NIL) e.status = STAT_FULL;
               else begin
                  used[s] = 1;
                  deadline[s] = r.now + {1'b0, r.delay};
                  period[s] = r.delay;
                  tag[s] = r.tag;
                  flags[s] = {r.skip, r.rep};
                  insert_slot(s);
                  e.new_handle = s[3:0];
               end
            end
            FUNC_CANCEL: begin
               if (!used[r.handle]) e.status = STAT_NOT_ACTIVE;
               else begin
                  remove_slot(r.handle);
                  used[r.handle] = 0;
               end
            end
            FUNC_RUN: begin
               s = head;
               if (s == NIL || !due_by(deadline[s], r.now)) e.status = STAT_NOTHING;
               else begin
                  e.fired = 1;
                  e.fired_tag = tag[s];
                  head = link[s];
                  if (flags[s][0]) begin
                     deadline[s] = r.now + {1'b0, period[s]};
                     insert_slot(s);
                  end else used[s] = 0;
               end
            end
            default: ;
         endcase
         e.next_wait = {16'd0, idle_wait};
         cur = head;
         n = 0;
         while (cur < NIL && n < NSLOT) begin
            if (!flags[cur][1]) begin
               e.next_wait = deadline[cur] - r.now;
               break;
            end
            cur = link[cur];
            n++;
         end
         pending.push_back(e);
      endfunction

      // compare a response with the oldest expectation
      function void check_response(event_rsp_type a);
         event_rsp_type e;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, a.status);
            errors++;
         end
         if (a.new_handle !== e.new_handle) begin
            $error("new_handle: expected %0d, actual %0d", e.new_handle, a.new_handle);
            errors++;
         end
         if (a.fired !== e.fired) begin
            $error("fired: expected %0d, actual %0d", e.fired, a.fired);
            errors++;
         end
         if (a.fired_tag !== e.fired_tag) begin
            $error("fired_tag: expected %0d, actual %0d", e.fired_tag, a.fired_tag);
            errors++;
         end
         if (a.next_wait !== e.next_wait) begin
            $error("next_wait: expected %0d, actual %0d", $signed(e.next_wait),
                   $signed(a.next_wait));
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   event_queue_scoreboard sb;
   logic [31:0] clock_now;
   bit          calm;
   bit          hold_rsp;
   int          watch;

   always #6 clock = ~clock;

   timed_event_queue #(.QUEUE_SLOTS(NSLOT)) i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_data
   );

   // check each accepted response word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response('{rsp_tuser, rsp_tdata[3:0], rsp_tdata[4], rsp_tdata[12:5],
                             rsp_tdata[44:13]});
   end

   // receiver: random stalls, long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         watch <= 0;
      else watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_word(event_req_type r);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= r.func;
      req_tdata <= {3'd0, r.handle, r.skip, r.tag, r.rep, r.delay, r.now};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
   endtask

   task automatic idle_sender();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      idle_sender();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [15:0] v);
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.idle_wait = v;
   endtask

   function automatic event_req_type make_req(logic [1:0] f, logic [31:0] d, logic rp,
                                               logic [7:0] t, logic sk, logic [3:0] h);
      event_req_type r;
      r = '{f, clock_now, d[30:0], rp, t, sk, h};
      return r;
   endfunction

   // one random word, mostly well formed against the current list
   function automatic event_req_type random_req();
      event_req_type r;
      int k;
      logic [31:0] d;
      k = $urandom_range(0, 99);
      clock_now = clock_now + $urandom_range(0, 40);
      if ($urandom_range(0, 30) == 0) clock_now = $urandom;
      d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
      r = make_req(FUNC_REGISTER, d, 1'($urandom_range(0, 1)), 8'($urandom),
                   $urandom_range(0, 3) == 0, 4'($urandom));
      if (k < 40) r.func = FUNC_REGISTER;
      else if (k < 55) begin
         r.func = FUNC_CANCEL;
         if ($urandom_range(0, 3) != 0)
            for (int i = 0; i < 16; i++) begin
               int s;
               s = $urandom_range(0, NSLOT - 1);
               if (sb.used[s]) begin
                  r.handle = s[3:0];
                  break;
               end
            end
      end else if (k < 97) r.func = FUNC_RUN;
      else r.func = FUNC_UNUSED;
      return r;
   endfunction

   initial begin
      logic [15:0] settings[4];
      sb = new();
      clock_now = 32'd1000;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty queue, extremes, every operation and corner
      send_word(make_req(FUNC_RUN, 0, 0, 0, 0, 0));
      send_word(make_req(FUNC_CANCEL, 0, 0, 0, 0, 4'hF));
      send_word(make_req(FUNC_UNUSED, 32'hFFFF_FFFF, 1, 8'hFF, 1, 4'hF));
      clock_now = 32'hFFFF_FFF0;
      send_word(make_req(FUNC_REGISTER, 32'h7FFF_FFFF, 0, 8'hFF, 0, 0));
      send_word(make_req(FUNC_REGISTER, 32'h20, 1, 8'h01, 0, 0));
      send_word(make_req(FUNC_REGISTER, 32'h20, 0, 8'h02, 1, 0));
      send_word(make_req(FUNC_REGISTER, 0, 1, 8'h03, 1, 0));
      send_word(make_req(FUNC_RUN, 0, 0, 0, 0, 0));
      send_word(make_req(FUNC_CANCEL, 0, 0, 0, 0, 4'd1));
      send_word(make_req(FUNC_CANCEL, 0, 0, 0, 0, 4'd1));
      clock_now = 32'h0000_0040;
      send_word(make_req(FUNC_RUN, 0, 0, 0, 0, 0));
      send_word(make_req(FUNC_RUN, 0, 0, 0, 0, 0));
      for (int i = 0; i < 15; i++)
         send_word(make_req(FUNC_REGISTER, 32'(i * 3), i[0], 8'(i), i[1], 0));
      drain();
      write_csr(16'd0);

      // random phases with settings changes, long hold-off in the first
      settings = '{16'hFFFF, 16'd1, 16'h8000, 16'd500};
      for (int ph = 0; ph < 4; ph++) begin
         if (ph == 3) calm = 1;
         if (ph == 0) begin
            fork
               begin
                  hold_rsp = 1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 0;
               end
               for (int i = 0; i < 30; i++) send_word(random_req());
            join
         end
         for (int i = 0; i < 180; i++) send_word(random_req());
         drain();
         write_csr(settings[ph]);
      end

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
